// ===== hdl/dmc_pkg.sv =====
// Shared constants, types and the step-response table for the DMC control law.
`default_nettype none

package dmc_pkg;

   // Horizon and tap store geometry
   localparam int DYNAMIC_HORIZON = 60;
   localparam int TAPS            = DYNAMIC_HORIZON - 1;
   localparam int TAP_W           = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int FILL_W          = $clog2(TAPS + 1);

   // Field widths
   localparam int IN_W    = 16;
   localparam int ERR_W   = IN_W + 1;
   localparam int GAIN_W  = 20;
   localparam int DRIVE_W = 20;
   localparam int PREV_W  = 21;
   localparam int INCR_W  = 22;
   localparam int COEF_W  = 11;

   // Stream payload widths
   localparam int REQ_W = 2 * IN_W;
   localparam int RSP_W = 24;

   // Arithmetic widths
   localparam int PROD_W     = INCR_W + COEF_W + 1;
   localparam int ACC_W      = PROD_W + TAP_W + 1;
   localparam int GPROD_W    = GAIN_W + 1 + ERR_W;
   localparam int GAIN_SHIFT = 12;
   localparam int HIST_SHIFT = 20;
   localparam int GAIN_HALF  = 2 ** (GAIN_SHIFT - 1);
   localparam int HIST_HALF  = 2 ** (HIST_SHIFT - 1);
   localparam int GTERM_W    = GPROD_W - GAIN_SHIFT;
   localparam int HTERM_W    = ACC_W - HIST_SHIFT;
   localparam int SUM_W      = ((GTERM_W > HTERM_W) ? GTERM_W : HTERM_W) + 2;

   // Register reset and drive limits
   localparam logic [GAIN_W-1:0]          GAIN_RESET = GAIN_W'(7130);
   localparam logic signed [DRIVE_W-1:0]  DRIVE_MAX  = DRIVE_W'(524032);
   localparam logic signed [DRIVE_W-1:0]  DRIVE_MIN  = DRIVE_W'(-524288);
   localparam logic signed [SUM_W-1:0]    SUM_MAX    = SUM_W'(524032);
   localparam logic signed [SUM_W-1:0]    SUM_MIN    = SUM_W'(-524288);

   // Step-response coefficients, unsigned Q0.20
   localparam int TABLE_LEN = 59;
   localparam int TBL_W     = 6;
   localparam logic [COEF_W-1:0] COEF_TABLE [TABLE_LEN] = '{
      11'd1153, 11'd1468, 11'd1573, 11'd1678, 11'd1678, 11'd1678, 11'd1678, 11'd1573,
      11'd1468, 11'd1363, 11'd1363, 11'd1258, 11'd1153, 11'd1049, 11'd944,  11'd944,
      11'd839,  11'd734,  11'd734,  11'd629,  11'd629,  11'd524,  11'd419,  11'd419,
      11'd419,  11'd315,  11'd315,  11'd315,  11'd210,  11'd210,  11'd210,  11'd210,
      11'd210,  11'd105,  11'd105,  11'd105,  11'd105,  11'd105,  11'd105,  11'd105,
      11'd105,  11'd0,    11'd105,  11'd105,  11'd0,    11'd105,  11'd0,    11'd0,
      11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,
      11'd0,    11'd0,    11'd0
   };

   // Taps past the end of the table weigh nothing
   function automatic logic [COEF_W-1:0] coeff_at(input logic [TAP_W-1:0] idx);
      logic [COEF_W-1:0] val;
      val = '0;
      if (int'(idx) < TABLE_LEN) begin
         val = COEF_TABLE[TBL_W'(idx)];
      end
      return val;
   endfunction

   // Controller to datapath commands
   typedef struct packed {
      logic             start;
      logic             issue;
      logic [TAP_W-1:0] tap;
      logic             sum;
      logic             commit;
   } dmc_cmd_type;

endpackage

`default_nettype wire

// ===== hdl/dmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== hdl/dmc_ctrl.sv =====
// Sequencer for the DMC control law: accept, tap sweep, drain, sum, commit.
`default_nettype none

module dmc_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output dmc_pkg::dmc_cmd_type cmd
);

   import dmc_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_MAC    = 6'b000010,
      S_DRAIN1 = 6'b000100,
      S_DRAIN2 = 6'b001000,
      S_SUM    = 6'b010000,
      S_COMMIT = 6'b100000
   } dmc_state_type;

   dmc_state_type    state_ff, state_in;
   logic [TAP_W-1:0] tap_ff, tap_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      tap_in     = tap_ff;
      cmd        = '0;
      cmd.tap    = tap_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               tap_in    = '0;
               state_in  = S_MAC;
            end
         end
         S_MAC: begin
            cmd.issue = 1'b1;
            if (tap_ff == TAP_W'(TAPS - 1)) begin
               state_in = S_DRAIN1;
            end else begin
               tap_in = tap_ff + TAP_W'(1);
            end
         end
         S_DRAIN1: begin
            state_in = S_DRAIN2;
         end
         S_DRAIN2: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result flag until the transaction completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Never overwrite a result that has not been taken
   a_commit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("commit while result register occupied");

   // An accepted transaction starts the sweep at the newest tap
   a_accept_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_MAC && tap_ff == '0))
      else $error("sweep did not start after accept");

   // Tap index stays inside the store
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC) |-> (tap_ff <= TAP_W'(TAPS - 1)))
      else $error("tap index beyond store");

   // A commit presents a result on the next cycle
   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit did not raise result valid");

endmodule

`default_nettype wire

// ===== hdl/dmc_dpath.sv =====
// Datapath for the DMC control law: error, gain product, history MAC, saturation.
`default_nettype none

module dmc_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dmc_pkg::dmc_cmd_type          cmd,
   input  wire logic                          csr_we,
   input  wire logic [dmc_pkg::GAIN_W-1:0]    csr_wdata,
   input  wire logic [dmc_pkg::REQ_W-1:0]     req_tdata,
   output logic      [dmc_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser
);

   import dmc_pkg::*;

   // Configuration and persistent state
   logic [GAIN_W-1:0]         gain_ff;
   logic signed [PREV_W-1:0]  prev_ff;
   logic [TAP_W-1:0]          wp_ff;
   logic [FILL_W-1:0]         fill_ff;

   // Per-item working registers
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [GPROD_W-1:0] gprod_ff;
   logic                      s1_valid_ff, s1_live_ff, s2_valid_ff;
   logic [TAP_W-1:0]          s1_tap_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [DRIVE_W-1:0] drive_ff;
   logic                      sat_ff;

   // Combinational values
   logic signed [IN_W-1:0]    meas, setp;
   logic signed [TAP_W+1:0]   addr_diff;
   logic [TAP_W-1:0]          raddr;
   logic [INCR_W-1:0]         rdata;
   logic signed [GPROD_W-1:0] gp_round;
   logic signed [ACC_W-1:0]   acc_round;
   logic signed [GTERM_W-1:0] gterm;
   logic signed [HTERM_W-1:0] hterm;
   logic signed [DRIVE_W-1:0] drive_in;
   logic                      sat_in;
   logic signed [INCR_W-1:0]  incr;

   assign meas = $signed(req_tdata[IN_W-1:0]);
   assign setp = $signed(req_tdata[REQ_W-1:IN_W]);

   // Tap k sits k+1 places behind the write pointer, wrapping round the store
   always_comb begin
      addr_diff = $signed({2'b00, wp_ff}) - $signed({2'b00, cmd.tap}) - (TAP_W+2)'(1);
      if (addr_diff < 0) begin
         addr_diff = addr_diff + (TAP_W+2)'(TAPS);
      end
      raddr = addr_diff[TAP_W-1:0];
   end

   dmc_ram #(
      .WIDTH (INCR_W),
      .DEPTH (TAPS)
   ) u_incr_ram (
      .clock (clock),
      .we    (cmd.commit),
      .waddr (wp_ff),
      .wdata (incr),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Round both terms half up, then combine
   always_comb begin
      gp_round  = gprod_ff + GPROD_W'(GAIN_HALF);
      acc_round = acc_ff + ACC_W'(HIST_HALF);
      gterm     = GTERM_W'(gp_round >>> GAIN_SHIFT);
      hterm     = HTERM_W'(acc_round >>> HIST_SHIFT);
   end

   // Clip to the drive range and form the new increment
   always_comb begin
      sat_in   = 1'b0;
      drive_in = DRIVE_W'(sum_ff);
      if (sum_ff > SUM_MAX) begin
         drive_in = DRIVE_MAX;
         sat_in   = 1'b1;
      end else if (sum_ff < SUM_MIN) begin
         drive_in = DRIVE_MIN;
         sat_in   = 1'b1;
      end
      incr = INCR_W'(drive_in) - INCR_W'(prev_ff);
   end

   // Control state: gain, previous drive, store pointer and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         prev_ff <= '0;
         wp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (csr_we) begin
            gain_ff <= csr_wdata;
         end
         if (cmd.commit) begin
            prev_ff <= PREV_W'(drive_in);
            if (wp_ff == TAP_W'(TAPS - 1)) begin
               wp_ff <= '0;
            end else begin
               wp_ff <= wp_ff + TAP_W'(1);
            end
            if (fill_ff != FILL_W'(TAPS)) begin
               fill_ff <= fill_ff + FILL_W'(1);
            end
         end
      end
   end

   // MAC pipeline flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_live_ff  <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s1_live_ff  <= cmd.issue && (FILL_W'(cmd.tap) < fill_ff);
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         err_ff <= $signed({setp[IN_W-1], setp}) - $signed({meas[IN_W-1], meas});
      end
      if (cmd.issue) begin
         gprod_ff <= $signed({1'b0, gain_ff}) * err_ff;
      end
      s1_tap_ff <= cmd.tap;
      // Taps never written yet read as zero
      if (s1_live_ff) begin
         prod_ff <= $signed(rdata) * $signed({1'b0, coeff_at(s1_tap_ff)});
      end else begin
         prod_ff <= '0;
      end
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (s2_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.sum) begin
         sum_ff <= SUM_W'(prev_ff) + SUM_W'(gterm) - SUM_W'(hterm);
      end
      if (cmd.commit) begin
         drive_ff <= drive_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_tdata = {(RSP_W - DRIVE_W)'(0), drive_ff};
   assign rsp_tuser = sat_ff;

endmodule

`default_nettype wire

// ===== hdl/dmc_control_law.sv =====
// Top level of the analytic single-input DMC control law.
// Sequence from input transaction to result valid: 59-tap MAC sweep, two pipeline
// drain states, a sum state, then a commit state that waits for a free result slot.
// A new item is accepted only after the last commits; the increment store has one read port.
// Reset (synchronous): gain 7130, previous drive zero and all past increments read as zero.
`default_nettype none

module dmc_control_law (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [dmc_pkg::REQ_W-1:0]  req_tdata,   // [15:0] measured_output, [31:16] setpoint
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [dmc_pkg::RSP_W-1:0]  rsp_tdata,   // [19:0] drive, [23:20] zero
   output logic                            rsp_tuser,   // [0] saturated
   input  wire logic                       csr_we,
   input  wire logic [dmc_pkg::GAIN_W-1:0] csr_wdata    // error_gain, Q8.12
);

   import dmc_pkg::*;

   dmc_cmd_type cmd;

   dmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dmc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire
